FILE: design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, switched off while reset is held
`define CHK_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// clocked check that also holds through reset
`define CHK_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: design/pbx_pkg.sv
`timescale 1ns / 1ps

package pbx_pkg;

    // table size; line numbers on the ports are five bits, the dial target is eight
    localparam int LINE_COUNT = 32;
    localparam int LINE_W     = 5;
    localparam int OP_W       = 3;
    localparam int TARGET_W   = 8;
    localparam int STATE_W    = 3;

    typedef logic [LINE_W-1:0]   t_line;
    typedef logic [OP_W-1:0]     t_op;
    typedef logic [TARGET_W-1:0] t_target;
    typedef logic [STATE_W-1:0]  t_state;
    typedef t_state [LINE_COUNT-1:0] t_state_vec;

    // event codes
    localparam t_op OP_REGISTER = 3'd0;
    localparam t_op OP_UNREG    = 3'd1;
    localparam t_op OP_PICKUP   = 3'd2;
    localparam t_op OP_HANGUP   = 3'd3;
    localparam t_op OP_DIAL     = 3'd4;
    localparam t_op OP_CHAT     = 3'd5;
    localparam t_op OP_SHUTDOWN = 3'd6;

    // line states
    localparam t_state ST_ON_HOOK   = 3'd0;
    localparam t_state ST_RINGING   = 3'd1;
    localparam t_state ST_DIAL_TONE = 3'd2;
    localparam t_state ST_RING_BACK = 3'd3;
    localparam t_state ST_BUSY      = 3'd4;
    localparam t_state ST_CONNECTED = 3'd5;
    localparam t_state ST_ERROR     = 3'd6;

    // one notification word
    typedef struct packed {
        logic   note_valid;
        t_line  dest;
        logic   is_chat;
        t_state code;
        logic   has_num;
        t_line  number;
    } t_note;

    // everything one event produces
    typedef struct packed {
        logic  status;
        logic  two;
        t_note note0;
        t_note note1;
    } t_result;

    // table writes for one event
    typedef struct packed {
        logic   reg_set;
        logic   reg_clr;
        t_line  reg_idx;
        logic   w0_en;
        t_line  w0_idx;
        t_state w0_st;
        logic   w1_en;
        t_line  w1_idx;
        t_state w1_st;
        logic   peer_wr;
        t_line  peer_a;
        t_line  peer_t;
        logic   sd_set;
    } t_update;

    typedef struct packed {
        logic  found;
        t_line idx;
    } t_free;

    function automatic t_note mk_note(t_line dest, logic chat, t_state code,
                                      logic has_num, t_line num);
        t_note n;
        n.note_valid = 1'b1;
        n.dest       = dest;
        n.is_chat    = chat;
        n.code       = code;
        n.has_num    = has_num;
        n.number     = has_num ? num : '0;
        return n;
    endfunction

    // report a line's current state back to it
    function automatic t_note tell_state(t_line a, t_state s, t_line peer_a);
        t_note n;
        if (s == ST_ON_HOOK) begin
            n = mk_note(a, 1'b0, s, 1'b1, a);
        end else if (s == ST_CONNECTED) begin
            n = mk_note(a, 1'b0, s, 1'b1, peer_a);
        end else begin
            n = mk_note(a, 1'b0, s, 1'b0, '0);
        end
        return n;
    endfunction

    // lowest line whose registered bit is clear
    function automatic t_free find_free(logic [LINE_COUNT-1:0] regd);
        t_free f;
        f = '0;
        for (int i = LINE_COUNT - 1; i >= 0; i--) begin
            if (!regd[i]) begin
                f.found = 1'b1;
                f.idx   = LINE_W'(i);
            end
        end
        return f;
    endfunction

endpackage

FILE: design/pbx_evt_eval.sv
`timescale 1ns / 1ps

module pbx_evt_eval (
    input  pbx_pkg::t_op                   i_op,
    input  pbx_pkg::t_line                 i_actor,
    input  pbx_pkg::t_target               i_target,
    input  logic                           i_sd,
    input  logic [pbx_pkg::LINE_COUNT-1:0] i_reg,
    input  pbx_pkg::t_state_vec            i_st,
    input  pbx_pkg::t_line                 i_peer_a,
    output pbx_pkg::t_result               o_res,
    output pbx_pkg::t_update               o_upd
);
    import pbx_pkg::*;

    t_state s;
    t_state ps;
    logic   pr;
    t_line  tl;
    t_free  ff;
    t_state want;
    t_note  pn;
    t_note  an;
    logic   pv;
    logic   av;
    logic   status;

    assign s  = i_st[i_actor];
    assign ps = i_st[i_peer_a];
    assign pr = i_reg[i_peer_a];
    assign tl = i_target[LINE_W-1:0];
    assign ff = find_free(i_reg);

    // peer state expected while hanging up
    always_comb begin
        case (s)
            ST_CONNECTED: want = ST_CONNECTED;
            ST_RING_BACK: want = ST_RINGING;
            default:      want = ST_RING_BACK;
        endcase
    end

    // event decode: peer note, actor note and table writes
    always_comb begin
        pn     = '0;
        an     = '0;
        pv     = 1'b0;
        av     = 1'b0;
        status = 1'b0;
        o_upd  = '0;
        o_upd.peer_a = i_actor;
        o_upd.peer_t = tl;
        case (i_op)
            OP_SHUTDOWN: begin
                o_upd.sd_set = 1'b1;
            end
            OP_REGISTER: begin
                if (i_sd || !ff.found) begin
                    status = 1'b1;
                end else begin
                    o_upd.reg_set = 1'b1;
                    o_upd.reg_idx = ff.idx;
                    o_upd.w0_en   = 1'b1;
                    o_upd.w0_idx  = ff.idx;
                    o_upd.w0_st   = ST_ON_HOOK;
                    an = mk_note(ff.idx, 1'b0, ST_ON_HOOK, 1'b1, ff.idx);
                    av = 1'b1;
                end
            end
            OP_UNREG, OP_PICKUP, OP_HANGUP, OP_DIAL, OP_CHAT: begin
                if (!i_reg[i_actor]) begin
                    status = 1'b1;
                end else if (i_op == OP_UNREG) begin
                    o_upd.reg_clr = 1'b1;
                    o_upd.reg_idx = i_actor;
                end else if (i_op == OP_HANGUP) begin
                    if ((s inside {ST_CONNECTED, ST_RING_BACK, ST_RINGING}) &&
                        !(pr && ps == want)) begin
                        // peer gone: nothing happens
                        status = 1'b0;
                    end else begin
                        if (s inside {ST_CONNECTED, ST_RING_BACK, ST_RINGING}) begin
                            o_upd.w1_en  = 1'b1;
                            o_upd.w1_idx = i_peer_a;
                            pv = 1'b1;
                            if (s == ST_RING_BACK) begin
                                o_upd.w1_st = ST_ON_HOOK;
                                pn = mk_note(i_peer_a, 1'b0, ST_ON_HOOK, 1'b1, i_peer_a);
                            end else begin
                                o_upd.w1_st = ST_DIAL_TONE;
                                pn = mk_note(i_peer_a, 1'b0, ST_DIAL_TONE, 1'b0, '0);
                            end
                        end
                        o_upd.w0_en  = 1'b1;
                        o_upd.w0_idx = i_actor;
                        o_upd.w0_st  = ST_ON_HOOK;
                        an = mk_note(i_actor, 1'b0, ST_ON_HOOK, 1'b1, i_actor);
                        av = !i_sd;
                    end
                end else if (i_sd) begin
                    status = 1'b1;
                end else if (i_op == OP_PICKUP) begin
                    if (s == ST_ON_HOOK) begin
                        o_upd.w0_en  = 1'b1;
                        o_upd.w0_idx = i_actor;
                        o_upd.w0_st  = ST_DIAL_TONE;
                        an = mk_note(i_actor, 1'b0, ST_DIAL_TONE, 1'b0, '0);
                        av = 1'b1;
                    end else if (s == ST_RINGING) begin
                        if (pr && ps == ST_RING_BACK) begin
                            o_upd.w1_en  = 1'b1;
                            o_upd.w1_idx = i_peer_a;
                            o_upd.w1_st  = ST_CONNECTED;
                            o_upd.w0_en  = 1'b1;
                            o_upd.w0_idx = i_actor;
                            o_upd.w0_st  = ST_CONNECTED;
                            pn = mk_note(i_peer_a, 1'b0, ST_CONNECTED, 1'b1, i_actor);
                            an = mk_note(i_actor, 1'b0, ST_CONNECTED, 1'b1, i_peer_a);
                            pv = 1'b1;
                            av = 1'b1;
                        end
                    end else begin
                        an = tell_state(i_actor, s, i_peer_a);
                        av = 1'b1;
                    end
                end else if (i_op == OP_DIAL) begin
                    if (i_target >= LINE_COUNT) begin
                        status = 1'b1;
                    end else if (s != ST_DIAL_TONE) begin
                        an = tell_state(i_actor, s, i_peer_a);
                        av = 1'b1;
                    end else if (!i_reg[tl]) begin
                        o_upd.w0_en  = 1'b1;
                        o_upd.w0_idx = i_actor;
                        o_upd.w0_st  = ST_ERROR;
                        an = mk_note(i_actor, 1'b0, ST_ERROR, 1'b0, '0);
                        av = 1'b1;
                    end else if (tl == i_actor || i_st[tl] != ST_ON_HOOK) begin
                        o_upd.w0_en  = 1'b1;
                        o_upd.w0_idx = i_actor;
                        o_upd.w0_st  = ST_BUSY;
                        an = mk_note(i_actor, 1'b0, ST_BUSY, 1'b0, '0);
                        av = 1'b1;
                    end else begin
                        o_upd.w1_en   = 1'b1;
                        o_upd.w1_idx  = tl;
                        o_upd.w1_st   = ST_RINGING;
                        o_upd.w0_en   = 1'b1;
                        o_upd.w0_idx  = i_actor;
                        o_upd.w0_st   = ST_RING_BACK;
                        o_upd.peer_wr = 1'b1;
                        pn = mk_note(tl, 1'b0, ST_RINGING, 1'b0, '0);
                        an = mk_note(i_actor, 1'b0, ST_RING_BACK, 1'b0, '0);
                        pv = 1'b1;
                        av = 1'b1;
                    end
                end else begin
                    // chat
                    if (s == ST_CONNECTED) begin
                        if (pr && ps == ST_CONNECTED) begin
                            pn = mk_note(i_peer_a, 1'b1, ST_ON_HOOK, 1'b0, '0);
                            an = mk_note(i_actor, 1'b0, ST_CONNECTED, 1'b1, i_peer_a);
                            pv = 1'b1;
                            av = 1'b1;
                        end
                    end else begin
                        an = tell_state(i_actor, s, i_peer_a);
                        av = 1'b1;
                        status = 1'b1;
                    end
                end
            end
            default: begin
                status = 1'b0;
            end
        endcase
    end

    // peer note goes out first
    always_comb begin
        o_res.status = status;
        o_res.two    = pv && av;
        o_res.note0  = pv ? pn : (av ? an : '0);
        o_res.note1  = an;
    end

endmodule

FILE: design/pbx_res_buf.sv
`timescale 1ns / 1ps

module pbx_res_buf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  pbx_pkg::t_result i_res,
    input  logic             i_ready,
    output logic             o_can_load,
    output logic             o_valid,
    output pbx_pkg::t_note   o_head,
    output logic             o_status,
    output logic             o_last
);
    import pbx_pkg::*;

    logic [1:0] r_cnt;
    logic [1:0] n_cnt;
    t_note      r_q0;
    t_note      r_q1;
    logic       r_status;
    logic       pop;

    assign pop        = o_valid && i_ready;
    assign o_valid    = (r_cnt != 2'd0);
    assign o_last     = (r_cnt == 2'd1);
    assign o_head     = r_q0;
    assign o_status   = r_status;
    assign o_can_load = (r_cnt == 2'd0) || (r_cnt == 2'd1 && pop);

    // words left to deliver
    always_comb begin
        if (i_load) begin
            n_cnt = i_res.two ? 2'd2 : 2'd1;
        end else if (pop) begin
            n_cnt = r_cnt - 2'd1;
        end else begin
            n_cnt = r_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    // payload: load a new event or shift the second word forward
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_q0     <= i_res.note0;
            r_q1     <= i_res.note1;
            r_status <= i_res.status;
        end else if (pop && r_cnt == 2'd2) begin
            r_q0 <= r_q1;
        end
    end

endmodule

FILE: design/pbx_line_call_state_table.sv
`timescale 1ns / 1ps

// Line call-state table for a small exchange. Events enter an input register,
// are decoded combinationally against the line table and leave through a result
// buffer that holds up to two words (peer notice first, then the actor's).
// While each event gives one word and the output takes each word, a new event
// can be accepted every cycle; an event giving two words holds the result
// buffer until its second word is taken, the buffer draining one word per cycle
// while the output is ready. The first word is shown once the event has passed
// the input register and been loaded into the result buffer.
// The table updates when the event moves into the result buffer.
module pbx_line_call_state_table (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  pbx_pkg::t_op       i_op,
    input  pbx_pkg::t_line     i_actor_line,
    input  pbx_pkg::t_target   i_dial_target,
    output logic               o_valid,
    input  logic               i_ready,
    output logic               o_status,
    output logic               o_note_valid,
    output pbx_pkg::t_line     o_dest_line,
    output logic               o_is_chat,
    output pbx_pkg::t_state    o_state_code,
    output logic               o_has_number,
    output pbx_pkg::t_line     o_number,
    output logic               o_last
);
    import pbx_pkg::*;

    `include "assert_macros.svh"

    logic                  r_in_vld;
    t_op                   r_op;
    t_line                 r_actor;
    t_target               r_target;
    logic [LINE_COUNT-1:0] r_reg;
    t_state_vec            r_state;
    t_line                 r_peer [LINE_COUNT];
    logic                  r_sd;

    logic    can_load;
    logic    advance;
    t_result res;
    t_update upd;
    t_note   head;

    assign advance = r_in_vld && can_load;
    assign o_ready = !r_in_vld || can_load;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_in_vld <= 1'b1;
        end else if (advance) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_op     <= i_op;
            r_actor  <= i_actor_line;
            r_target <= i_dial_target;
        end
    end

    // event decode
    pbx_evt_eval u_eval (
        .i_op     (r_op),
        .i_actor  (r_actor),
        .i_target (r_target),
        .i_sd     (r_sd),
        .i_reg    (r_reg),
        .i_st     (r_state),
        .i_peer_a (r_peer[r_actor]),
        .o_res    (res),
        .o_upd    (upd)
    );

    // line table; actor write goes last so it wins
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reg   <= '0;
            r_state <= {LINE_COUNT{ST_ON_HOOK}};
            r_sd    <= 1'b0;
        end else if (advance) begin
            if (upd.sd_set) begin
                r_sd <= 1'b1;
            end
            if (upd.reg_set) begin
                r_reg[upd.reg_idx] <= 1'b1;
            end
            if (upd.reg_clr) begin
                r_reg[upd.reg_idx] <= 1'b0;
            end
            if (upd.w1_en) begin
                r_state[upd.w1_idx] <= upd.w1_st;
            end
            if (upd.w0_en) begin
                r_state[upd.w0_idx] <= upd.w0_st;
            end
        end
    end

    // peer links, written by a successful dial
    always_ff @(posedge i_clk) begin
        if (advance && upd.peer_wr) begin
            r_peer[upd.peer_t] <= upd.peer_a;
            r_peer[upd.peer_a] <= upd.peer_t;
        end
    end

    // result buffer
    pbx_res_buf u_buf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (advance),
        .i_res      (res),
        .i_ready    (i_ready),
        .o_can_load (can_load),
        .o_valid    (o_valid),
        .o_head     (head),
        .o_status   (o_status),
        .o_last     (o_last)
    );

    assign o_note_valid = head.note_valid;
    assign o_dest_line  = head.dest;
    assign o_is_chat    = head.is_chat;
    assign o_state_code = head.code;
    assign o_has_number = head.has_num;
    assign o_number     = head.number;

    // checks
    `CHK_CLK(a_load_shows, i_clk, i_rst_n, advance |=> o_valid,
             "event loaded but no word shown")
    `CHK_CLK(a_empty_last, i_clk, i_rst_n, (o_valid && !o_note_valid) |-> o_last,
             "empty word not last")
    `CHK_CLK(a_conn_num, i_clk, i_rst_n,
             (o_valid && o_note_valid && !o_is_chat && o_state_code == ST_CONNECTED)
             |-> o_has_number, "connected notice without number")
    `CHK_CLK(a_no_skip, i_clk, i_rst_n,
             !(o_valid && !o_last && o_ready && !r_in_vld && can_load),
             "buffer free while words pending")

endmodule
